/* rtl/core/mouse_packet_cursor_tracker_defines.svh */
// Assertion macros used by the checker file of the cursor tracker.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define MPCT_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define MPCT_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mpct_pkg.sv */
`default_nettype none

package mpct_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COL_W      = 7;
    localparam int unsigned ROW_W      = 6;
    localparam int unsigned COLS_CFG_W = 8;
    localparam int unsigned ROWS_CFG_W = 7;
    localparam int unsigned BTN_W      = 3;
    localparam int unsigned SWAP_W     = 3;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd25;
    localparam logic [COLS_CFG_W-1:0] COLS_MAX   = 8'd128;
    localparam logic [ROWS_CFG_W-1:0] ROWS_MAX   = 7'd64;

    // Register index, taken from the word address.
    localparam logic REG_SCREEN_COLS = 1'b0;
    localparam logic REG_SCREEN_ROWS = 1'b1;

    typedef enum logic [1:0] {
        POS_FLAGS = 2'd0,
        POS_X     = 2'd1,
        POS_Y     = 2'd2
    } t_byte_pos;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              aux_data;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  old_col;
        logic [ROW_W-1:0]  old_row;
        logic [COL_W-1:0]  new_col;
        logic [ROW_W-1:0]  new_row;
        logic [BTN_W-1:0]  button_state;
        logic [BTN_W-1:0]  button_changes;
        logic [SWAP_W-1:0] new_cell_swaps;
    } t_out_item;

    typedef struct packed {
        logic              complete;
        logic [BTN_W-1:0]  buttons;
        logic [BYTE_W-1:0] x_delta;
        logic [BYTE_W-1:0] y_delta;
    } t_packet;

    typedef struct packed {
        logic [COLS_CFG_W-1:0] screen_cols;
        logic [ROWS_CFG_W-1:0] screen_rows;
    } t_screen_cfg;

endpackage

`default_nettype wire

/* rtl/core/mouse_packet_cursor_tracker.sv */
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------
// in        | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
// out       | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
// config    | input     | psel / penable / pready   | paddr, pwdata, prdata
//
// One byte per cycle is taken unless the input register stalls; a byte waits in the
// input register, and a completed packet's result is then held in the output register.
// The cursor add-and-clamp sits between those two registers and is combinational.
// Reset is synchronous and clears the grouping, the cursor, the buttons and both
// valid flags; the screen size returns to 80 by 25.
// While a result waits, bytes that finish no packet still flow; a third byte stalls
// in the input register until the output register is free or being taken.
`default_nettype none

module mouse_packet_cursor_tracker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  mpct_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output mpct_pkg::t_out_item             o_out_item,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [mpct_pkg::APB_ADDR_W-1:0] paddr,
    input  wire  [mpct_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mpct_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mpct_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;

    t_screen_cfg cfg;
    t_packet     packet;
    t_out_item   result;
    logic        out_free;
    logic        consume;
    logic        emit;

    mpct_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mpct_packet_asm u_packet_asm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_in_item),
        .i_step   (consume),
        .o_packet (packet)
    );

    mpct_cursor_upd u_cursor_upd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_packet (packet),
        .i_update (emit),
        .i_cfg    (cfg),
        .o_item   (result)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign consume    = r_in_valid && (!packet.complete || out_free);
    assign emit       = consume && packet.complete;
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

/* rtl/core/mpct_cfg_regs.sv */
`default_nettype none

module mpct_cfg_regs (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [mpct_pkg::APB_ADDR_W-1:0] paddr,
    input  wire  [mpct_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mpct_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output mpct_pkg::t_screen_cfg           o_cfg
);
    import mpct_pkg::*;

    logic [COLS_CFG_W-1:0] r_screen_cols;
    logic [ROWS_CFG_W-1:0] r_screen_rows;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_cols <= COLS_RESET;
            r_screen_rows <= ROWS_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SCREEN_COLS: r_screen_cols <= pwdata[COLS_CFG_W-1:0];
                REG_SCREEN_ROWS: r_screen_rows <= pwdata[ROWS_CFG_W-1:0];
                default:         r_screen_cols <= r_screen_cols;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SCREEN_COLS: prdata = {{(APB_DATA_W-COLS_CFG_W){1'b0}}, r_screen_cols};
            REG_SCREEN_ROWS: prdata = {{(APB_DATA_W-ROWS_CFG_W){1'b0}}, r_screen_rows};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.screen_cols = r_screen_cols;
    assign o_cfg.screen_rows = r_screen_rows;

endmodule

`default_nettype wire

/* rtl/core/mpct_packet_asm.sv */
`default_nettype none

module mpct_packet_asm (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mpct_pkg::t_in_item   i_item,
    input  wire                  i_step,
    output mpct_pkg::t_packet    o_packet
);
    import mpct_pkg::*;

    t_byte_pos         r_pos;
    t_byte_pos         n_pos;
    logic [BTN_W-1:0]  r_flags;
    logic [BYTE_W-1:0] r_x_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FLAGS;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

    // Only the button bits of the flags byte are ever used.
    always_ff @(posedge i_clk) begin
        if (i_step && i_item.aux_data && (r_pos == POS_FLAGS)) begin
            r_flags <= i_item.data_byte[BTN_W-1:0];
        end
        if (i_step && i_item.aux_data && (r_pos == POS_X)) begin
            r_x_delta <= i_item.data_byte;
        end
    end

    always_comb begin
        n_pos             = r_pos;
        o_packet.complete = 1'b0;
        o_packet.buttons  = r_flags;
        o_packet.x_delta  = r_x_delta;
        o_packet.y_delta  = i_item.data_byte;
        // Bytes from the keyboard port leave the grouping where it is.
        if (i_item.aux_data) begin
            unique case (r_pos)
                POS_FLAGS: n_pos = POS_X;
                POS_X:     n_pos = POS_Y;
                POS_Y: begin
                    n_pos             = POS_FLAGS;
                    o_packet.complete = 1'b1;
                end
                default:   n_pos = POS_FLAGS;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mpct_cursor_upd.sv */
`default_nettype none

module mpct_cursor_upd (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mpct_pkg::t_packet     i_packet,
    input  wire                   i_update,
    input  mpct_pkg::t_screen_cfg i_cfg,
    output mpct_pkg::t_out_item   o_item
);
    import mpct_pkg::*;

    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [BTN_W-1:0]      r_prev_btn;

    logic [COLS_CFG_W-1:0] eff_cols;
    logic [ROWS_CFG_W-1:0] eff_rows;
    logic [COLS_CFG_W-1:0] cols_last;
    logic [ROWS_CFG_W-1:0] rows_last;
    logic signed [9:0]     col_sum;
    logic signed [9:0]     row_sum;
    logic [COL_W-1:0]      new_col;
    logic [ROW_W-1:0]      new_row;
    logic [BTN_W-1:0]      changes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_prev_btn <= '0;
        end else if (i_update) begin
            r_col      <= new_col;
            r_row      <= new_row;
            r_prev_btn <= i_packet.buttons;
        end
    end

    always_comb begin
        // A size of zero behaves as one, and oversized screens are capped.
        priority if (i_cfg.screen_cols == '0) begin
            eff_cols = 8'd1;
        end else if (i_cfg.screen_cols > COLS_MAX) begin
            eff_cols = COLS_MAX;
        end else begin
            eff_cols = i_cfg.screen_cols;
        end
        priority if (i_cfg.screen_rows == '0) begin
            eff_rows = 7'd1;
        end else if (i_cfg.screen_rows > ROWS_MAX) begin
            eff_rows = ROWS_MAX;
        end else begin
            eff_rows = i_cfg.screen_rows;
        end
        cols_last = eff_cols - 8'd1;
        rows_last = eff_rows - 7'd1;

        col_sum = $signed({3'b000, r_col})
                + $signed({{2{i_packet.x_delta[7]}}, i_packet.x_delta});
        row_sum = $signed({4'b0000, r_row})
                - $signed({{2{i_packet.y_delta[7]}}, i_packet.y_delta});

        priority if (col_sum[9]) begin
            new_col = '0;
        end else if (col_sum[8:0] >= {1'b0, eff_cols}) begin
            new_col = cols_last[COL_W-1:0];
        end else begin
            new_col = col_sum[COL_W-1:0];
        end

        priority if (row_sum[9]) begin
            new_row = '0;
        end else if (row_sum[8:0] >= {2'b00, eff_rows}) begin
            new_row = rows_last[ROW_W-1:0];
        end else begin
            new_row = row_sum[ROW_W-1:0];
        end

        changes = i_packet.buttons ^ r_prev_btn;
    end

    assign o_item.old_col        = r_col;
    assign o_item.old_row        = r_row;
    assign o_item.new_col        = new_col;
    assign o_item.new_row        = new_row;
    assign o_item.button_state   = i_packet.buttons;
    assign o_item.button_changes = changes;
    assign o_item.new_cell_swaps = 3'd1 + {2'b00, changes[0]} + {2'b00, changes[1]}
                                 + {2'b00, changes[2]};

endmodule

`default_nettype wire

/* rtl/core/mpct_checker.sv */
`default_nettype none
`include "mouse_packet_cursor_tracker_defines.svh"

module mpct_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input mpct_pkg::t_out_item o_out_item
);
    import mpct_pkg::*;

    // Cursor and buttons as the last delivered item left them.
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;
    logic [BTN_W-1:0] r_last_btn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= '0;
            r_last_row <= '0;
            r_last_btn <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_last_col <= o_out_item.new_col;
            r_last_row <= o_out_item.new_row;
            r_last_btn <= o_out_item.button_state;
        end
    end

    `MPCT_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "stalled result changed or dropped")
    `MPCT_ASSERT_RST(a_cursor_chain, i_clk, i_rst_n, o_out_valid |-> o_out_item.old_col == r_last_col && o_out_item.old_row == r_last_row, "old cell differs from previous new cell")
    `MPCT_ASSERT_RST(a_button_chain, i_clk, i_rst_n, o_out_valid |-> o_out_item.button_changes == (o_out_item.button_state ^ r_last_btn), "button changes do not follow previous packet")
    `MPCT_ASSERT_RST(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled with output register empty")
    `MPCT_ASSERT(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mpct_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int DRAIN_WAIT  = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 175;
    localparam int PRINT_CAP   = 40;

    localparam logic [APB_ADDR_W-1:0] ADDR_COLS = {REG_SCREEN_COLS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_ROWS = {REG_SCREEN_ROWS, 2'b00};

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_item = '0;
    logic                  out_ready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;

    wire                   o_in_ready;
    wire                   o_out_valid;
    t_out_item             o_out_item;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    mouse_packet_cursor_tracker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Tracker state mirrored by the testbench.
    logic [COLS_CFG_W-1:0] cfg_cols = COLS_RESET;
    logic [ROWS_CFG_W-1:0] cfg_rows = ROWS_RESET;
    t_byte_pos             trk_pos = POS_FLAGS;
    logic [BYTE_W-1:0]     trk_flags = '0;
    logic [BYTE_W-1:0]     trk_xdelta = '0;
    logic [COL_W-1:0]      trk_col = '0;
    logic [ROW_W-1:0]      trk_row = '0;
    logic [BTN_W-1:0]      trk_buttons = '0;

    t_out_item pending_moves[$];
    t_dir_row  dir_rows[$];
    t_out_item head_move;

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int mouse_bytes = 0;
    int ignored_bytes = 0;
    int moves_checked = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d moves still awaited.",
                     cycle_count, pending_moves.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int eff_size(input int v, input int max_v);
        if (v == 0) return 1;
        return (v > max_v) ? max_v : v;
    endfunction

    function automatic int clamp_cell(input int v, input int limit);
        if (v < 0) return 0;
        if (v >= limit) return limit - 1;
        return v;
    endfunction

    // Feeds one byte to the mirrored tracker; returns 1 when a packet completes.
    function automatic bit track_byte(input t_in_item it, output t_out_item move);
        int               cols;
        int               rows;
        int               col_next;
        int               row_next;
        logic [BTN_W-1:0] btn;
        logic [BTN_W-1:0] chg;
        move = '0;
        if (!it.aux_data) return 1'b0;
        case (trk_pos)
            POS_FLAGS: begin
                trk_flags = it.data_byte;
                trk_pos   = POS_X;
                return 1'b0;
            end
            POS_X: begin
                trk_xdelta = it.data_byte;
                trk_pos    = POS_Y;
                return 1'b0;
            end
            default: begin
                trk_pos  = POS_FLAGS;
                cols     = eff_size(int'(cfg_cols), int'(COLS_MAX));
                rows     = eff_size(int'(cfg_rows), int'(ROWS_MAX));
                col_next = clamp_cell(int'(trk_col) + int'($signed(trk_xdelta)), cols);
                row_next = clamp_cell(int'(trk_row) - int'($signed(it.data_byte)), rows);
                btn      = trk_flags[BTN_W-1:0];
                chg      = btn ^ trk_buttons;
                move.old_col        = trk_col;
                move.old_row        = trk_row;
                move.new_col        = col_next[COL_W-1:0];
                move.new_row        = row_next[ROW_W-1:0];
                move.button_state   = btn;
                move.button_changes = chg;
                move.new_cell_swaps = SWAP_W'(1 + $countones(chg));
                trk_col     = col_next[COL_W-1:0];
                trk_row     = row_next[ROW_W-1:0];
                trk_buttons = btn;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic t_out_item make_move(input int old_c, input int old_r, input int new_c,
                                            input int new_r, input int btn, input int chg,
                                            input int swp);
        t_out_item m;
        m.old_col        = old_c[COL_W-1:0];
        m.old_row        = old_r[ROW_W-1:0];
        m.new_col        = new_c[COL_W-1:0];
        m.new_row        = new_r[ROW_W-1:0];
        m.button_state   = btn[BTN_W-1:0];
        m.button_changes = chg[BTN_W-1:0];
        m.new_cell_swaps = swp[SWAP_W-1:0];
        return m;
    endfunction

    function automatic void dir_push(input logic [BYTE_W-1:0] b, input logic aux,
                                     input bit typed = 1'b0, input t_out_item want = '0);
        t_dir_row r;
        r.item  = '{data_byte: b, aux_data: aux};
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_delta();
        case ($urandom_range(7))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'h00;
            3: return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("Mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("move %0d %s got %0d expected %0d",
                                      moves_checked, name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_moves.size() == 0) begin
                report_mismatch("cursor move reported with none outstanding");
            end else begin
                head_move = pending_moves.pop_front();
                check_field("old_col", o_out_item.old_col, head_move.old_col);
                check_field("old_row", o_out_item.old_row, head_move.old_row);
                check_field("new_col", o_out_item.new_col, head_move.new_col);
                check_field("new_row", o_out_item.new_row, head_move.new_row);
                check_field("button_state", o_out_item.button_state,
                            head_move.button_state);
                check_field("button_changes", o_out_item.button_changes,
                            head_move.button_changes);
                check_field("new_cell_swaps", o_out_item.new_cell_swaps,
                            head_move.new_cell_swaps);
            end
            moves_checked++;
        end
    end

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_COLS)
            cfg_cols = data[COLS_CFG_W-1:0];
        else
            cfg_rows = data[ROWS_CFG_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // The typed expectation, where given, stands in for the mirrored one.
    task automatic send_byte(input t_in_item it, input bit typed = 1'b0,
                             input t_out_item want = '0);
        t_out_item move;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (track_byte(it, move))
            pending_moves.push_back(typed ? want : move);
        if (it.aux_data)
            mouse_bytes++;
        else
            ignored_bytes++;
    endtask

    task automatic send_mouse(input logic [BYTE_W-1:0] b);
        if ($urandom_range(9) == 0)
            send_byte('{data_byte: BYTE_W'($urandom), aux_data: 1'b0});
        send_byte('{data_byte: b, aux_data: 1'b1});
    endtask

    task automatic send_packet(input logic [BYTE_W-1:0] flags, input logic [BYTE_W-1:0] dx,
                               input logic [BYTE_W-1:0] dy);
        send_mouse(flags);
        send_mouse(dx);
        send_mouse(dy);
    endtask

    // Holds the sender off until every move has come back, then lets the pipe empty.
    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_moves.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic run_random(input int n_bytes);
        int start;
        int pick;
        start = mouse_bytes;
        while (mouse_bytes - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 85)
                send_packet(BYTE_W'($urandom), pick_delta(), pick_delta());
            else if (pick < 94)
                send_byte('{data_byte: BYTE_W'($urandom), aux_data: 1'b0});
            else if (pick < 98)
                // A stray byte throws the grouping out of step with the packets.
                send_byte('{data_byte: BYTE_W'($urandom), aux_data: 1'b1});
            else
                wait_drained(0);
        end
        while (trk_pos != POS_FLAGS)
            send_mouse(BYTE_W'($urandom));
        // Park the cursor in the far corner so the next resize may shrink under it.
        send_packet(BYTE_W'($urandom), 8'h7F, 8'h80);
    endtask

    initial begin
        int cols_val;
        int rows_val;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(ADDR_COLS, APB_DATA_W'(80));
        write_reg(ADDR_ROWS, APB_DATA_W'(25));

        dir_push(8'h08, 1'b1);
        dir_push(8'h00, 1'b1);
        dir_push(8'h00, 1'b1, 1'b1, make_move(0, 0, 0, 0, 0, 0, 1));
        dir_push(8'h55, 1'b0);
        dir_push(8'hFF, 1'b1);
        dir_push(8'hAA, 1'b0);
        dir_push(8'h7F, 1'b1);
        dir_push(8'h80, 1'b1, 1'b1, make_move(0, 0, 79, 24, 7, 7, 4));
        dir_push(8'h09, 1'b1);
        dir_push(8'h80, 1'b1);
        dir_push(8'h7F, 1'b1, 1'b1, make_move(79, 24, 0, 0, 1, 6, 3));
        dir_push(8'h0A, 1'b1);
        dir_push(8'h05, 1'b1);
        dir_push(8'hFE, 1'b1);
        dir_push(8'h0C, 1'b1);
        dir_push(8'hFF, 1'b1);
        dir_push(8'h01, 1'b1);
        dir_push(8'h00, 1'b0);
        dir_push(8'h00, 1'b1);
        dir_push(8'h00, 1'b1);
        dir_push(8'h00, 1'b1);
        dir_push(8'hFF, 1'b0);
        foreach (dir_rows[i])
            send_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        wait_drained(DRAIN_WAIT);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cols_val = 128; rows_val = 64; end
                1: begin cols_val = 0; rows_val = 0; end
                2: begin cols_val = 255; rows_val = 127; end
                3: begin cols_val = 1; rows_val = 1; end
                4: begin cols_val = 80; rows_val = 25; end
                5: begin cols_val = $urandom_range(128, 1); rows_val = $urandom_range(64, 1); end
                6: begin cols_val = 3; rows_val = 2; end
                default: begin
                    cols_val = $urandom_range(255);
                    rows_val = $urandom_range(127);
                end
            endcase
            case (p % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 65; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 65; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            write_reg(ADDR_COLS, APB_DATA_W'(cols_val));
            write_reg(ADDR_ROWS, APB_DATA_W'(rows_val));
            run_random(PHASE_BYTES);
            wait_drained(DRAIN_WAIT);
        end

        $display("Sent %0d mouse bytes and %0d ignored bytes; %0d cursor moves checked.",
                 mouse_bytes, ignored_bytes, moves_checked);
        $display("Screen sizes ran from zero and one cell up to oversized, under mixed stalls.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
